// ----- design/lqc_pkg.sv -----
// Shared types, constants and helper functions of the lepton quality classifier.
// Used by every module of the block; depends on nothing else.

package lqc_pkg;

    // Saturation limit of every count, clipped to what a 7-bit count field can hold.
    localparam int MAX_LEPTONS = 64;
    localparam int COUNT_W     = 7;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((MAX_LEPTONS < 127) ? MAX_LEPTONS : 127);

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Stream payload widths.
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;
    localparam int CLASS_W    = 3;

    // Depth of the queue between the classifier and the counter stage.
    localparam int QUEUE_DEPTH = 2;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ETA_LIMIT        = 3'd0,
        CFG_VETO_PT_MIN      = 3'd1,
        CFG_GOOD_MU_PT_MIN   = 3'd2,
        CFG_GOOD_EL_PT_MIN   = 3'd3,
        CFG_MU_ISO_MAX       = 3'd4,
        CFG_EL_ISO_MAX       = 3'd5
    } t_cfg_index;

    // Classification codes carried from the front to the back.
    typedef enum logic [CLASS_W-1:0] {
        CLS_REJECT  = 3'd0,
        CLS_GOOD_MU = 3'd1,
        CLS_VETO_MU = 3'd2,
        CLS_GOOD_EL = 3'd3,
        CLS_VETO_EL = 3'd4,
        CLS_OTHER   = 3'd5,
        CLS_END     = 3'd6
    } t_class;

    // Saturating increment of one tally.
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] a);
        logic [COUNT_W-1:0] r;
        r = (a < COUNT_CAP) ? (a + COUNT_W'(1)) : COUNT_CAP;
        return r;
    endfunction

    // Saturating sum of two tallies.
    function automatic logic [COUNT_W-1:0] sat_sum(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, COUNT_CAP}) ? COUNT_CAP : s[COUNT_W-1:0];
    endfunction

endpackage

// ----- design/lqc_front.sv -----
// Front end of the lepton quality classifier: configuration registers and cuts.
// Depends on lqc_pkg; feeds lqc_queue with one class code per accepted item.

module lqc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [lqc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lqc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Input stream.
    input  logic                          i_valid,
    output logic                          o_ready,
    // Fields from bit 0 up: lepton_pt[16], lepton_eta[14], particle_id[16],
    // tight_flag[1], rel_isolation[16], zero pad[1].
    input  logic [lqc_pkg::IN_DATA_W-1:0] i_data,
    // Fields from bit 0 up: action[1].
    input  logic [lqc_pkg::IN_USER_W-1:0] i_user,
    // Queue write side.
    output logic                          o_push,
    output lqc_pkg::t_class               o_class,
    input  logic                          i_queue_ready
);

    logic [12:0] r_eta_limit;
    logic [15:0] r_veto_pt_min;
    logic [15:0] r_good_mu_pt_min;
    logic [15:0] r_good_el_pt_min;
    logic [15:0] r_mu_iso_max;
    logic [15:0] r_el_iso_max;

    logic               action;
    logic [15:0]        lepton_pt;
    logic signed [13:0] lepton_eta;
    logic signed [15:0] particle_id;
    logic               tight_flag;
    logic [15:0]        rel_isolation;
    logic [13:0]        eta_mag;
    logic               common_pass;
    logic               is_muon;
    logic               is_electron;
    logic               good_mu;
    logic               good_el;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_limit      <= 13'd2458;
            r_veto_pt_min    <= 16'd160;
            r_good_mu_pt_min <= 16'd400;
            r_good_el_pt_min <= 16'd400;
            r_mu_iso_max     <= 16'd123;
            r_el_iso_max     <= 16'd143;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lqc_pkg::CFG_ETA_LIMIT:      r_eta_limit      <= i_cfg_wdata[12:0];
                lqc_pkg::CFG_VETO_PT_MIN:    r_veto_pt_min    <= i_cfg_wdata;
                lqc_pkg::CFG_GOOD_MU_PT_MIN: r_good_mu_pt_min <= i_cfg_wdata;
                lqc_pkg::CFG_GOOD_EL_PT_MIN: r_good_el_pt_min <= i_cfg_wdata;
                lqc_pkg::CFG_MU_ISO_MAX:     r_mu_iso_max     <= i_cfg_wdata;
                lqc_pkg::CFG_EL_ISO_MAX:     r_el_iso_max     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Unpack the record fields.
    assign action        = i_user[0];
    assign lepton_pt     = i_data[15:0];
    assign lepton_eta    = i_data[29:16];
    assign particle_id   = i_data[45:30];
    assign tight_flag    = i_data[46];
    assign rel_isolation = i_data[62:47];

    // Magnitude of eta; the most negative code yields 8192 as an unsigned value.
    assign eta_mag = lepton_eta[13] ? (14'd0 - 14'(lepton_eta)) : 14'(lepton_eta);

    // Common cuts and flavour checks.
    assign common_pass = (lepton_pt > r_veto_pt_min) && (eta_mag <= {1'b0, r_eta_limit});
    assign is_muon     = (particle_id == 16'sd13) || (particle_id == -16'sd13);
    assign is_electron = (particle_id == 16'sd11) || (particle_id == -16'sd11);
    assign good_mu     = (lepton_pt > r_good_mu_pt_min) && tight_flag
                         && (rel_isolation < r_mu_iso_max);
    assign good_el     = (lepton_pt > r_good_el_pt_min) && tight_flag
                         && (rel_isolation < r_el_iso_max);

    // Class code of the item on the input.
    always_comb begin
        if (action) begin
            o_class = lqc_pkg::CLS_END;
        end else if (!common_pass) begin
            o_class = lqc_pkg::CLS_REJECT;
        end else if (is_muon) begin
            o_class = good_mu ? lqc_pkg::CLS_GOOD_MU : lqc_pkg::CLS_VETO_MU;
        end else if (is_electron) begin
            o_class = good_el ? lqc_pkg::CLS_GOOD_EL : lqc_pkg::CLS_VETO_EL;
        end else begin
            o_class = lqc_pkg::CLS_OTHER;
        end
    end

    // A transfer happens whenever the queue has room.
    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready;

endmodule

// ----- design/lqc_queue.sv -----
// Small register queue of class codes between the front and the back.
// Depends on lqc_pkg for the class type and the queue depth.

module lqc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lqc_pkg::t_class i_class,
    output logic            o_ready,
    output logic            o_valid,
    output lqc_pkg::t_class o_class,
    input  logic            i_pop
);

    localparam int PTR_W = (lqc_pkg::QUEUE_DEPTH > 1) ? $clog2(lqc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lqc_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(lqc_pkg::QUEUE_DEPTH - 1);

    lqc_pkg::t_class  r_slot [lqc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_W'(lqc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_class = r_slot[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: ;
            endcase
        end
    end

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_class;
        end
    end

endmodule

// ----- design/lqc_back.sv -----
// Back end of the lepton quality classifier: event tallies and result register.
// Depends on lqc_pkg; drains class codes from lqc_queue.

module lqc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Queue read side.
    input  logic                           i_valid,
    input  lqc_pkg::t_class                i_class,
    output logic                           o_pop,
    // Result stream.
    output logic                           o_valid,
    input  logic                           i_ready,
    // Fields from bit 0 up: good_muon_count[7], good_electron_count[7],
    // good_lepton_count[7], veto_muon_count[7], veto_electron_count[7],
    // veto_lepton_count[7], zero pad[6].
    output logic [lqc_pkg::OUT_DATA_W-1:0] o_data,
    // Fields from bit 0 up: lepton_class[3].
    output logic [lqc_pkg::CLASS_W-1:0]    o_user,
    // event_end.
    output logic                           o_last
);

    localparam int CW = lqc_pkg::COUNT_W;

    logic [CW-1:0] r_good_mu;
    logic [CW-1:0] r_good_el;
    logic [CW-1:0] r_veto_mu;
    logic [CW-1:0] r_veto_el;
    logic [CW-1:0] n_good_mu;
    logic [CW-1:0] n_good_el;
    logic [CW-1:0] n_veto_mu;
    logic [CW-1:0] n_veto_el;

    logic                           r_out_valid;
    logic [lqc_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [lqc_pkg::CLASS_W-1:0]    r_out_user;
    logic                           r_out_last;
    logic [lqc_pkg::OUT_DATA_W-1:0] n_out_data;

    logic [CW-1:0] rep_good_mu;
    logic [CW-1:0] rep_good_el;
    logic [CW-1:0] rep_veto_mu;
    logic [CW-1:0] rep_veto_el;
    logic          is_end;

    // Take a code whenever the result register is empty or being drained.
    assign o_pop  = i_valid && (!r_out_valid || i_ready);
    assign is_end = (i_class == lqc_pkg::CLS_END);

    // Tally update for the code at the head of the queue.
    always_comb begin
        n_good_mu = r_good_mu;
        n_good_el = r_good_el;
        n_veto_mu = r_veto_mu;
        n_veto_el = r_veto_el;
        case (i_class)
            lqc_pkg::CLS_GOOD_MU: n_good_mu = lqc_pkg::sat_inc(r_good_mu);
            lqc_pkg::CLS_VETO_MU: n_veto_mu = lqc_pkg::sat_inc(r_veto_mu);
            lqc_pkg::CLS_GOOD_EL: n_good_el = lqc_pkg::sat_inc(r_good_el);
            lqc_pkg::CLS_VETO_EL: n_veto_el = lqc_pkg::sat_inc(r_veto_el);
            lqc_pkg::CLS_END: begin
                n_good_mu = '0;
                n_good_el = '0;
                n_veto_mu = '0;
                n_veto_el = '0;
            end
            default: ;
        endcase
    end

    // The end item reports the counts before they are cleared.
    assign rep_good_mu = is_end ? r_good_mu : n_good_mu;
    assign rep_good_el = is_end ? r_good_el : n_good_el;
    assign rep_veto_mu = is_end ? r_veto_mu : n_veto_mu;
    assign rep_veto_el = is_end ? r_veto_el : n_veto_el;

    assign n_out_data = {6'd0,
                         lqc_pkg::sat_sum(rep_veto_mu, rep_veto_el),
                         rep_veto_el,
                         rep_veto_mu,
                         lqc_pkg::sat_sum(rep_good_mu, rep_good_el),
                         rep_good_el,
                         rep_good_mu};

    // Tally registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good_mu <= '0;
            r_good_el <= '0;
            r_veto_mu <= '0;
            r_veto_el <= '0;
        end else if (o_pop) begin
            r_good_mu <= n_good_mu;
            r_good_el <= n_good_el;
            r_veto_mu <= n_veto_mu;
            r_veto_el <= n_veto_el;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
            r_out_user <= i_class;
            r_out_last <= is_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_user  = r_out_user;
    assign o_last  = r_out_last;

endmodule

// ----- design/lepton_quality_classifier.sv -----
// Top level of the lepton quality classifier.
// Instantiates lqc_front, lqc_queue and lqc_back; depends on lqc_pkg.

// The block takes one lepton record or end-of-event marker per transfer and
// sustains one transfer per clock cycle on both streams unless the output
// stalls. Each accepted item yields exactly one result; its class code is
// queued, then loaded into the output register. The classifier cuts are
// evaluated in the cycle of the input transfer, a two-entry queue holds the
// class codes, and the counter stage updates the event tallies and loads
// the result register in the same cycle. Counts include the current lepton,
// saturate at the package limit, and an end item reports the final counts
// and clears them. The user writes configuration registers through the plain
// write port while no items are in flight; the block does not enforce it.

module lepton_quality_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [lqc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lqc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Input stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0 up: lepton_pt[16], lepton_eta[14], particle_id[16],
    // tight_flag[1], rel_isolation[16], zero pad[1].
    input  logic [lqc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0 up: action[1].
    input  logic [lqc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0 up: good_muon_count[7], good_electron_count[7],
    // good_lepton_count[7], veto_muon_count[7], veto_electron_count[7],
    // veto_lepton_count[7], zero pad[6].
    output logic [lqc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0 up: lepton_class[3].
    output logic [lqc_pkg::CLASS_W-1:0]    m_axis_tuser,
    // event_end.
    output logic                           m_axis_tlast
);

    logic            push;
    lqc_pkg::t_class push_class;
    logic            queue_ready;
    logic            queue_valid;
    lqc_pkg::t_class queue_class;
    logic            pop;

    // Classifier and configuration registers.
    lqc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .i_user        (s_axis_tuser),
        .o_push        (push),
        .o_class       (push_class),
        .i_queue_ready (queue_ready)
    );

    // Class code queue.
    lqc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_class (push_class),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_class (queue_class),
        .i_pop   (pop)
    );

    // Tallies and result register.
    lqc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_class (queue_class),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

// ----- tb/lqc_tally_checker.sv -----
// Checker of the lepton quality classifier: watches the configuration port and both streams,
// predicts every result from its own copy of the cuts and tallies, and compares field by field.
// Depends on lqc_pkg for the class codes, register indexes and port widths.

module lqc_tally_checker
    import lqc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // Fields from bit 0 up: lepton_pt, lepton_eta, particle_id, tight_flag, rel_isolation.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0 up: action.
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0 up: the six good and veto counts, seven bits each.
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0 up: lepton_class.
    input  logic [CLASS_W-1:0]    m_axis_tuser,
    input  logic                  m_axis_tlast,
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TALLY_CAP   = (MAX_LEPTONS < 127) ? MAX_LEPTONS : 127;
    localparam int MUON_ID     = 13;
    localparam int ELECTRON_ID = 11;

    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        t_class cls;
        t_count good_mu;
        t_count good_el;
        t_count good_all;
        t_count veto_mu;
        t_count veto_el;
        t_count veto_all;
        logic   event_end;
    } t_tally_result;

    // Cut values as last written, and the running tallies of the event.
    logic [12:0]   cut_eta_limit;
    logic [15:0]   cut_veto_pt;
    logic [15:0]   cut_mu_pt;
    logic [15:0]   cut_el_pt;
    logic [15:0]   cut_mu_iso;
    logic [15:0]   cut_el_iso;
    t_count        tally_good_mu;
    t_count        tally_good_el;
    t_count        tally_veto_mu;
    t_count        tally_veto_el;

    t_tally_result expected_tallies[$];
    t_tally_result want;
    int            result_idx = 0;
    int            fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        $display("[%0t] lqc_tally_checker: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(input string field, input int got, input int exp_val);
        if (got != exp_val) begin
            report_mismatch($sformatf("result %0d: %s is %0d, predicted %0d",
                                      result_idx, field, got, exp_val));
        end
    endtask

    // Addition that stops at the count limit.
    function automatic t_count capped_add(input t_count a, input t_count b);
        int s;
        s = int'(a) + int'(b);
        return (s > TALLY_CAP) ? t_count'(TALLY_CAP) : t_count'(s);
    endfunction

    // Classify one item, update the tallies and return the result it causes.
    function automatic t_tally_result predict_tally(input logic end_item,
                                                    input logic [IN_DATA_W-1:0] d);
        t_tally_result      r;
        logic [15:0]        pt;
        logic signed [13:0] eta;
        logic signed [15:0] pid;
        logic               tight;
        logic [15:0]        iso;
        int                 eta_mag;
        int                 id_mag;
        pt      = d[15:0];
        eta     = d[29:16];
        pid     = d[45:30];
        tight   = d[46];
        iso     = d[62:47];
        eta_mag = (eta < 0) ? -int'(eta) : int'(eta);
        id_mag  = (pid < 0) ? -int'(pid) : int'(pid);

        if (end_item) begin
            r.cls = CLS_END;
        end else if (pt <= cut_veto_pt || eta_mag > int'(cut_eta_limit)) begin
            r.cls = CLS_REJECT;
        end else if (id_mag == MUON_ID) begin
            if (pt > cut_mu_pt && tight && iso < cut_mu_iso) begin
                r.cls = CLS_GOOD_MU;
                tally_good_mu = capped_add(tally_good_mu, t_count'(1));
            end else begin
                r.cls = CLS_VETO_MU;
                tally_veto_mu = capped_add(tally_veto_mu, t_count'(1));
            end
        end else if (id_mag == ELECTRON_ID) begin
            if (pt > cut_el_pt && tight && iso < cut_el_iso) begin
                r.cls = CLS_GOOD_EL;
                tally_good_el = capped_add(tally_good_el, t_count'(1));
            end else begin
                r.cls = CLS_VETO_EL;
                tally_veto_el = capped_add(tally_veto_el, t_count'(1));
            end
        end else begin
            r.cls = CLS_OTHER;
        end

        r.good_mu   = tally_good_mu;
        r.good_el   = tally_good_el;
        r.good_all  = capped_add(tally_good_mu, tally_good_el);
        r.veto_mu   = tally_veto_mu;
        r.veto_el   = tally_veto_el;
        r.veto_all  = capped_add(tally_veto_mu, tally_veto_el);
        r.event_end = end_item;

        // The end item reports the event and starts the next one from zero.
        if (end_item) begin
            tally_good_mu = '0;
            tally_good_el = '0;
            tally_veto_mu = '0;
            tally_veto_el = '0;
        end
        return r;
    endfunction

    // Track configuration, predict on each input transfer, compare on each output transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cut_eta_limit = 13'd2458;
            cut_veto_pt   = 16'd160;
            cut_mu_pt     = 16'd400;
            cut_el_pt     = 16'd400;
            cut_mu_iso    = 16'd123;
            cut_el_iso    = 16'd143;
            tally_good_mu = '0;
            tally_good_el = '0;
            tally_veto_mu = '0;
            tally_veto_el = '0;
            expected_tallies.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ETA_LIMIT:      cut_eta_limit = i_cfg_wdata[12:0];
                    CFG_VETO_PT_MIN:    cut_veto_pt   = i_cfg_wdata;
                    CFG_GOOD_MU_PT_MIN: cut_mu_pt     = i_cfg_wdata;
                    CFG_GOOD_EL_PT_MIN: cut_el_pt     = i_cfg_wdata;
                    CFG_MU_ISO_MAX:     cut_mu_iso    = i_cfg_wdata;
                    CFG_EL_ISO_MAX:     cut_el_iso    = i_cfg_wdata;
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                expected_tallies.insert(expected_tallies.size(),
                                        predict_tally(s_axis_tuser[0], s_axis_tdata));
            end

            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_tallies.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no item pending",
                                              result_idx));
                end else begin
                    want = expected_tallies.pop_front();
                    check_field("lepton_class", int'(m_axis_tuser), int'(want.cls));
                    check_field("good_muon_count", int'(m_axis_tdata[6:0]), int'(want.good_mu));
                    check_field("good_electron_count", int'(m_axis_tdata[13:7]),
                                int'(want.good_el));
                    check_field("good_lepton_count", int'(m_axis_tdata[20:14]),
                                int'(want.good_all));
                    check_field("veto_muon_count", int'(m_axis_tdata[27:21]), int'(want.veto_mu));
                    check_field("veto_electron_count", int'(m_axis_tdata[34:28]),
                                int'(want.veto_el));
                    check_field("veto_lepton_count", int'(m_axis_tdata[41:35]),
                                int'(want.veto_all));
                    check_field("event_end", int'(m_axis_tlast), int'(want.event_end));
                end
                result_idx++;
            end
        end
        o_pending <= expected_tallies.size();
    end

endmodule

// ----- tb/tb_lepton_quality_classifier.sv -----
// Top of the lepton quality classifier testbench: clock, reset, configuration phases and stimulus.
// Instantiates the block and lqc_tally_checker, which predicts and compares; depends on lqc_pkg.

module tb_lepton_quality_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import lqc_pkg::*;

    localparam int MUON_ID        = 13;
    localparam int ELECTRON_ID    = 11;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 32;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int FIRST_UNUSED_INDEX = CFG_EL_ISO_MAX + 1;
    localparam int LAST_INDEX     = (1 << CFG_ADDR_W) - 1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [CLASS_W-1:0]    m_axis_tuser;
    logic                  m_axis_tlast;

    int pending;
    int fail_count;
    int idle_cycles = 0;
    int stall_pct = 0;
    int send_idle_pct = 0;

    // Cut values as last written, used to aim the stimulus at the thresholds.
    int aim_eta    = 2458;
    int aim_veto   = 160;
    int aim_mu_pt  = 400;
    int aim_el_pt  = 400;
    int aim_mu_iso = 123;
    int aim_el_iso = 143;

    lepton_quality_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lqc_tally_checker u_tally_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always #2 i_clk = ~i_clk;

    // The result side stalls at random with the probability of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: end the run when no transfer happens on either stream for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lepton_quality_classifier regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_lepton(input int pt, input int eta,
                                                         input int pid, input bit tight,
                                                         input int iso);
        return {1'b0, 16'(iso), tight, 16'(pid), 14'(eta), 16'(pt)};
    endfunction

    function automatic logic [IN_DATA_W-1:0] noise_word();
        return {1'b0, (IN_DATA_W-1)'({$urandom, $urandom})};
    endfunction

    // A lepton aimed at the current cuts; a tenth of them are pure noise.
    function automatic logic [IN_DATA_W-1:0] random_lepton(input int mu_share);
        int pt;
        int eta;
        int pid;
        int iso;
        int pt_cut;
        int iso_cut;
        bit is_mu;
        bit tight;
        if ($urandom_range(0, 9) == 0) begin
            return noise_word();
        end
        is_mu   = ($urandom_range(0, 99) < mu_share);
        pt_cut  = is_mu ? aim_mu_pt : aim_el_pt;
        iso_cut = is_mu ? aim_mu_iso : aim_el_iso;

        if ($urandom_range(0, 99) < 85) begin
            pid = is_mu ? MUON_ID : ELECTRON_ID;
        end else begin
            case ($urandom_range(0, 5))
                0:       pid = 0;
                1:       pid = 12;
                2:       pid = 14;
                3:       pid = -32768;
                4:       pid = 32767;
                default: pid = int'($urandom_range(0, 65535)) - 32768;
            endcase
        end
        if ($urandom_range(0, 1) != 0) begin
            pid = -pid;
        end

        case ($urandom_range(0, 5))
            0:       pt = aim_veto + int'($urandom_range(0, 2)) - 1;
            1:       pt = pt_cut + int'($urandom_range(0, 2)) - 1;
            2, 3:    pt = int'($urandom_range(clip(pt_cut, 0, 65535), 65535));
            4:       pt = int'($urandom_range(clip(aim_veto, 0, 65535), clip(pt_cut, 0, 65535)));
            default: pt = int'($urandom_range(0, 65535));
        endcase
        pt = clip(pt, 0, 65535);

        case ($urandom_range(0, 4))
            0:       eta = aim_eta + int'($urandom_range(0, 1));
            1, 2:    eta = int'($urandom_range(0, aim_eta));
            3:       eta = int'($urandom_range(0, 16383)) - 8192;
            default: eta = ($urandom_range(0, 3) == 0) ? -8192 : int'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 1) != 0) begin
            eta = -eta;
        end
        eta = clip(eta, -8192, 8191);

        case ($urandom_range(0, 3))
            0:       iso = iso_cut + int'($urandom_range(0, 1)) - 1;
            1, 2:    iso = int'($urandom_range(0, iso_cut));
            default: iso = int'($urandom_range(0, 65535));
        endcase
        iso   = clip(iso, 0, 65535);
        tight = ($urandom_range(0, 9) < 8);
        return pack_lepton(pt, eta, pid, tight, iso);
    endfunction

    // One transfer on the input stream, after a random idle stretch of the sender.
    task automatic send_item(input logic end_item, input logic [IN_DATA_W-1:0] payload);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= end_item;
        s_axis_tdata  <= payload;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every predicted result has been checked.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_ETA_LIMIT:      aim_eta    = int'(val[12:0]);
            CFG_VETO_PT_MIN:    aim_veto   = int'(val);
            CFG_GOOD_MU_PT_MIN: aim_mu_pt  = int'(val);
            CFG_GOOD_EL_PT_MIN: aim_el_pt  = int'(val);
            CFG_MU_ISO_MAX:     aim_mu_iso = int'(val);
            CFG_EL_ISO_MAX:     aim_el_iso = int'(val);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int eta_v;
        int veto_v;
        int mu_pt_v;
        int el_pt_v;
        int mu_iso_v;
        int el_iso_v;
        int sent;
        int ev_len;
        bit paused;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset cuts: every class, each cut at and beside its edge.
        send_item(1'b0, pack_lepton(aim_veto, 0, MUON_ID, 1, 0));
        send_item(1'b0, pack_lepton(aim_veto + 1, 0, MUON_ID, 1, 0));
        send_item(1'b0, pack_lepton(aim_mu_pt + 1, aim_eta, MUON_ID, 1, aim_mu_iso - 1));
        send_item(1'b0, pack_lepton(aim_mu_pt + 1, aim_eta + 1, MUON_ID, 1, 0));
        send_item(1'b0, pack_lepton(aim_mu_pt + 1, -aim_eta, -MUON_ID, 1, aim_mu_iso - 1));
        send_item(1'b0, pack_lepton(aim_mu_pt + 1, -aim_eta - 1, -MUON_ID, 1, 0));
        // The most negative eta is always beyond the limit.
        send_item(1'b0, pack_lepton(65535, -8192, MUON_ID, 1, 0));
        send_item(1'b0, pack_lepton(65535, 0, -MUON_ID, 1, aim_mu_iso));
        send_item(1'b0, pack_lepton(500, 100, MUON_ID, 0, 0));
        send_item(1'b0, pack_lepton(aim_mu_pt, 0, MUON_ID, 1, 0));
        send_item(1'b0, pack_lepton(aim_el_pt + 1, 0, ELECTRON_ID, 1, aim_el_iso - 1));
        send_item(1'b0, pack_lepton(aim_el_pt + 1, 0, -ELECTRON_ID, 1, aim_el_iso));
        send_item(1'b0, pack_lepton(aim_el_pt + 1, 0, ELECTRON_ID, 0, 0));
        send_item(1'b0, pack_lepton(aim_el_pt, 0, -ELECTRON_ID, 1, 0));
        // Other flavours, including the most negative and largest particle codes; then extreme electrons.
        send_item(1'b0, pack_lepton(1000, 0, 12, 1, 0));
        send_item(1'b0, pack_lepton(1000, 0, -32768, 1, 0));
        send_item(1'b0, pack_lepton(1000, 0, 32767, 1, 65535));
        send_item(1'b0, pack_lepton(0, 0, 0, 0, 0));
        send_item(1'b0, pack_lepton(1000, 8191, ELECTRON_ID, 1, 0));
        send_item(1'b0, pack_lepton(65535, 0, ELECTRON_ID, 1, 65535));
        // End items ignore their lepton fields; the second one closes an empty event.
        send_item(1'b1, noise_word());
        send_item(1'b1, noise_word());
        send_item(1'b0, pack_lepton(aim_el_pt + 1, 1, -ELECTRON_ID, 1, 0));
        send_item(1'b1, noise_word());

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();

            // Cut settings of this phase, the extremes among them.
            case (phase)
                1: begin
                    eta_v = 0; veto_v = 0; mu_pt_v = 0; el_pt_v = 0; mu_iso_v = 0; el_iso_v = 0;
                end
                2: begin
                    eta_v = 8191; veto_v = 0; mu_pt_v = 0; el_pt_v = 0;
                    mu_iso_v = 65535; el_iso_v = 65535;
                end
                3: begin
                    eta_v = $urandom_range(0, 8191); veto_v = 65535;
                    mu_pt_v = $urandom_range(0, 65535); el_pt_v = $urandom_range(0, 65535);
                    mu_iso_v = $urandom_range(0, 65535); el_iso_v = $urandom_range(0, 65535);
                end
                5: begin
                    eta_v = 8191; veto_v = 0; mu_pt_v = 65535; el_pt_v = 65535;
                    mu_iso_v = $urandom_range(0, 65535); el_iso_v = $urandom_range(0, 65535);
                end
                6: begin
                    eta_v = $urandom_range(0, 65535); veto_v = $urandom_range(0, 65535);
                    mu_pt_v = $urandom_range(0, 65535); el_pt_v = $urandom_range(0, 65535);
                    mu_iso_v = $urandom_range(0, 65535); el_iso_v = $urandom_range(0, 65535);
                end
                7: begin
                    eta_v = 2458; veto_v = 160; mu_pt_v = 400; el_pt_v = 400;
                    mu_iso_v = 123; el_iso_v = 143;
                end
                default: begin
                    eta_v = $urandom_range(1024, 4096); veto_v = $urandom_range(0, 400);
                    mu_pt_v = $urandom_range(200, 800); el_pt_v = $urandom_range(200, 800);
                    mu_iso_v = $urandom_range(50, 300); el_iso_v = $urandom_range(50, 300);
                end
            endcase

            // Bits above the eta field width are don't-care and get random values.
            if (phase == 6) begin
                write_reg(CFG_ETA_LIMIT, 16'(eta_v));
            end else begin
                write_reg(CFG_ETA_LIMIT, {3'($urandom), 13'(eta_v)});
            end
            write_reg(CFG_VETO_PT_MIN, 16'(veto_v));
            write_reg(CFG_GOOD_MU_PT_MIN, 16'(mu_pt_v));
            write_reg(CFG_GOOD_EL_PT_MIN, 16'(el_pt_v));
            write_reg(CFG_MU_ISO_MAX, 16'(mu_iso_v));
            write_reg(CFG_EL_ISO_MAX, 16'(el_iso_v));
            // A write to an unused index must leave every cut alone.
            write_reg(3'($urandom_range(FIRST_UNUSED_INDEX, LAST_INDEX)), 16'($urandom));
            i_cfg_we <= 1'b0;
            @(posedge i_clk);

            // Idling pattern of this phase.
            case (phase % 4)
                1:       begin send_idle_pct = 85; stall_pct <= 0;  end
                2:       begin send_idle_pct = 0;  stall_pct <= 85; end
                3:       begin send_idle_pct = 11; stall_pct <= 11; end
                default: begin send_idle_pct = 0;  stall_pct <= 0;  end
            endcase

            // One long event drives the counts into saturation: good ones, then veto ones.
            if (phase == 2 || phase == 5) begin
                ev_len = $urandom_range(140, 160);
                for (int j = 0; j < ev_len; j++) begin
                    send_item(1'b0, random_lepton((phase == 2) ? 90 : 20));
                end
                send_item(1'b1, noise_word());
            end

            // Events of random length, some of them empty.
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                ev_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                for (int j = 0; j < ev_len; j++) begin
                    send_item(1'b0, random_lepton(50));
                    sent++;
                end
                send_item(1'b1, noise_word());
                sent++;
                if (!paused && sent >= PHASE_ITEMS / 2) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("lepton_quality_classifier regression: pass");
        end else begin
            $display("lepton_quality_classifier regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/lqc_pkg.sv
design/lqc_front.sv
design/lqc_queue.sv
design/lqc_back.sv
design/lepton_quality_classifier.sv
tb/lqc_tally_checker.sv
tb/tb_lepton_quality_classifier.sv
